// ===== rtl/core/set_assoc_cache_tag_plru_top_macros.svh =====
// Assertion shorthands for the cache tag store.
`ifndef SET_ASSOC_CACHE_TAG_PLRU_TOP_MACROS_SVH
`define SET_ASSOC_CACHE_TAG_PLRU_TOP_MACROS_SVH

// Same-cycle implication.
`define SACP_ASSERT_IMP(lbl, ck, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SACP_ASSERT_NXT(lbl, ck, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/sacp_pkg.sv =====
`default_nettype none

package sacp_pkg;

  // Geometry
  localparam int NUM_SETS         = 32;
  localparam int LINE_OFFSET_BITS = 5;
  localparam int NUM_WAYS         = 4;
  localparam int ADDR_BITS        = 32;
  localparam int SET_BITS         = $clog2(NUM_SETS);
  localparam int TAG_BITS         = ADDR_BITS - LINE_OFFSET_BITS - SET_BITS;
  localparam int WAY_BITS         = 2;
  localparam int PLRU_BITS        = 3;
  localparam int CNT_BITS         = 32;

  // Request kinds
  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  // Victim way from the tree state
  localparam logic [WAY_BITS-1:0] VICTIM_ROM [8] = '{
    2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd3, 2'd2, 2'd3
  };

  // Next tree state, indexed by {state, referenced way}
  localparam logic [PLRU_BITS-1:0] PLRU_NEXT_ROM [32] = '{
    3'd6, 3'd4, 3'd1, 3'd0,
    3'd7, 3'd5, 3'd1, 3'd0,
    3'd6, 3'd4, 3'd3, 3'd2,
    3'd7, 3'd5, 3'd3, 3'd2,
    3'd6, 3'd4, 3'd1, 3'd0,
    3'd7, 3'd5, 3'd1, 3'd0,
    3'd6, 3'd4, 3'd3, 3'd2,
    3'd7, 3'd5, 3'd3, 3'd2
  };

  // Request transaction
  typedef struct packed {
    logic [ADDR_BITS-1:0] addr;
    logic                 req_type;
  } req_t;

  // Response transaction
  typedef struct packed {
    logic                hit;
    logic [WAY_BITS-1:0] way_used;
    logic                writeback_needed;
    logic [CNT_BITS-1:0] hit_total;
    logic [CNT_BITS-1:0] miss_total;
    logic [CNT_BITS-1:0] writeback_total;
  } rsp_t;

  // One set as held in the tag memory
  typedef struct packed {
    logic [NUM_WAYS-1:0][TAG_BITS-1:0] tag;
    logic [NUM_WAYS-1:0]               dirty;
    logic [NUM_WAYS-1:0]               valid;
    logic [PLRU_BITS-1:0]              plru;
  } set_row_t;

  // Lookup outcome handed back to the controller
  typedef struct packed {
    logic                hit;
    logic [WAY_BITS-1:0] way;
    logic                wb;
  } lk_res_t;

endpackage

`default_nettype wire

// ===== rtl/core/sacp_lookup.sv =====
`default_nettype none

module sacp_lookup
  import sacp_pkg::*;
(
  input  set_row_t              row_i,
  input  logic [TAG_BITS-1:0]   tag_i,
  input  logic                  is_write_i,
  output lk_res_t               res_o,
  output set_row_t              row_o
);

  logic [NUM_WAYS-1:0] match;
  logic                any_hit;
  logic [WAY_BITS-1:0] hit_way;
  logic [WAY_BITS-1:0] free_way;
  logic [WAY_BITS-1:0] vict_way;
  logic [WAY_BITS-1:0] way;
  logic                all_valid;
  logic                wb;

  // Per-way tag compare
  always_comb begin
    for (int w = 0; w < NUM_WAYS; w++) begin
      match[w] = row_i.valid[w] && (row_i.tag[w] == tag_i);
    end
  end

  // Lowest matching way and lowest free way
  always_comb begin
    hit_way  = '0;
    free_way = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (match[w]) begin
        hit_way = WAY_BITS'(w);
      end
      if (!row_i.valid[w]) begin
        free_way = WAY_BITS'(w);
      end
    end
  end

  assign any_hit   = |match;
  assign all_valid = &row_i.valid;
  assign vict_way  = VICTIM_ROM[row_i.plru];

  // Way selection and writeback detect
  always_comb begin
    if (any_hit) begin
      way = hit_way;
      wb  = 1'b0;
    end else if (all_valid) begin
      way = vict_way;
      wb  = row_i.dirty[vict_way];
    end else begin
      way = free_way;
      wb  = 1'b0;
    end
  end

  // Updated set row
  always_comb begin
    row_o = row_i;
    if (!any_hit) begin
      row_o.tag[way]   = tag_i;
      row_o.valid[way] = 1'b1;
      row_o.dirty[way] = 1'b0;
    end
    if (is_write_i == REQ_WRITE) begin
      row_o.dirty[way] = 1'b1;
    end
    row_o.plru = PLRU_NEXT_ROM[{row_i.plru, way}];
  end

  assign res_o.hit = any_hit;
  assign res_o.way = way;
  assign res_o.wb  = wb;

endmodule

`default_nettype wire

// ===== rtl/core/set_assoc_cache_tag_plru_top.sv =====
// Four-way cache tag store with tree pLRU and hit/miss/writeback counters.
// Each request is a read-modify-write of the set row memory: the row is read
// on accept, then looked up and written back as the response is registered,
// which waits for a free response register. No request is taken meanwhile.
// Reset: counters and a per-set row-valid flag clear at once; no clearing pass.
`default_nettype none

`include "set_assoc_cache_tag_plru_top_macros.svh"

module set_assoc_cache_tag_plru_top
  import sacp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  req_t in_data,
  output logic out_valid,
  input  logic out_stall,
  output rsp_t out_data
);

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_LOOKUP = 2'b10
  } state_t;

  state_t              state_r, state_nxt;
  logic                in_acc;
  logic                lk_done;

  // Set row memory and per-set initialized flags
  set_row_t            row_mem [NUM_SETS];
  logic [NUM_SETS-1:0] row_init_r;

  set_row_t            rd_row_r;
  logic                rd_init_r;
  logic [SET_BITS-1:0] set_r;
  logic [TAG_BITS-1:0] tag_r;
  logic                wr_r;
  logic [SET_BITS-1:0] in_set;

  set_row_t            cur_row;
  set_row_t            new_row;
  lk_res_t             lk_res;

  logic [CNT_BITS-1:0] hit_cnt_r, miss_cnt_r, wb_cnt_r;
  logic [CNT_BITS-1:0] hit_cnt_nxt, miss_cnt_nxt, wb_cnt_nxt;

  logic                out_valid_r;
  rsp_t                out_data_r;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign lk_done  = (state_r == ST_LOOKUP) && (!out_valid_r || !out_stall);
  assign in_set   = in_data.addr[LINE_OFFSET_BITS +: SET_BITS];

  // Control FSM
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) state_nxt = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        if (lk_done) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Request capture and memory read
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_row_r  <= row_mem[in_set];
      rd_init_r <= row_init_r[in_set];
      set_r     <= in_set;
      tag_r     <= in_data.addr[ADDR_BITS-1 -: TAG_BITS];
      wr_r      <= in_data.req_type;
    end
  end

  // Untouched sets read as all zero
  assign cur_row = rd_init_r ? rd_row_r : '0;

  sacp_lookup u_lookup (
    .row_i      (cur_row),
    .tag_i      (tag_r),
    .is_write_i (wr_r),
    .res_o      (lk_res),
    .row_o      (new_row)
  );

  // Write back the updated row
  always_ff @(posedge clk) begin
    if (lk_done) begin
      row_mem[set_r] <= new_row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_init_r <= '0;
    end else if (lk_done) begin
      row_init_r[set_r] <= 1'b1;
    end
  end

  // Statistics counters
  always_comb begin
    hit_cnt_nxt  = hit_cnt_r;
    miss_cnt_nxt = miss_cnt_r;
    wb_cnt_nxt   = wb_cnt_r;
    if (lk_res.hit) begin
      hit_cnt_nxt = hit_cnt_r + 1'b1;
    end else begin
      miss_cnt_nxt = miss_cnt_r + 1'b1;
    end
    if (lk_res.wb) begin
      wb_cnt_nxt = wb_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_cnt_r  <= '0;
      miss_cnt_r <= '0;
      wb_cnt_r   <= '0;
    end else if (lk_done) begin
      hit_cnt_r  <= hit_cnt_nxt;
      miss_cnt_r <= miss_cnt_nxt;
      wb_cnt_r   <= wb_cnt_nxt;
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (lk_done) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (lk_done) begin
      out_data_r.hit              <= lk_res.hit;
      out_data_r.way_used         <= lk_res.way;
      out_data_r.writeback_needed <= lk_res.wb;
      out_data_r.hit_total        <= hit_cnt_nxt;
      out_data_r.miss_total       <= miss_cnt_nxt;
      out_data_r.writeback_total  <= wb_cnt_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks
  `SACP_ASSERT_NXT(a_acc_lookup, clk, rst_n, in_acc, state_r == ST_LOOKUP, "accept without lookup")
  `SACP_ASSERT_IMP(a_hit_no_wb, clk, rst_n, lk_done && lk_res.hit, !lk_res.wb, "writeback on hit")
  `SACP_ASSERT_NXT(a_cnt_step, clk, rst_n, lk_done, 32'(hit_cnt_r + miss_cnt_r) == 32'($past(hit_cnt_r + miss_cnt_r) + 1), "access count off")

endmodule

`default_nettype wire

// ===== tb/tb_set_assoc_cache_tag_plru_top.sv =====
`timescale 1ns / 1ps

module tb_set_assoc_cache_tag_plru_top;
  import sacp_pkg::*;

  localparam int RUN_LIMIT    = 100000;
  localparam int HOLD_START   = 600;
  localparam int HOLD_CYCLES  = 200;
  localparam int DRAIN_CYCLES = 10;
  localparam int RANDOM_ITEMS = 400;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  req_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  rsp_t out_data;

  // Pending accesses and the responses they should produce
  req_t access_queue[$];
  rsp_t expected_rsps[$];
  int   mismatches = 0;
  int   cycle_count = 0;

  // Shadow copy of the tag store
  logic [NUM_WAYS-1:0]  shadow_valid [NUM_SETS];
  logic [NUM_WAYS-1:0]  shadow_dirty [NUM_SETS];
  logic [TAG_BITS-1:0]  shadow_tag   [NUM_SETS][NUM_WAYS];
  logic [PLRU_BITS-1:0] shadow_tree  [NUM_SETS];
  logic [CNT_BITS-1:0]  hits_seen;
  logic [CNT_BITS-1:0]  misses_seen;
  logic [CNT_BITS-1:0]  writebacks_seen;

  // Sender and receiver pacing
  int burst_left = 0;
  int gap_left = 0;
  int rx_cycles = 0;
  int hold_left = 0;
  int phase_left = 0;
  int stall_mode = 0;

  set_assoc_cache_tag_plru_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Look up one access in the shadow store and update it
  function automatic rsp_t cache_access(req_t req);
    logic [SET_BITS-1:0]  set_idx;
    logic [TAG_BITS-1:0]  tag;
    logic [WAY_BITS-1:0]  way;
    logic [PLRU_BITS-1:0] s;
    rsp_t rsp;
    set_idx = req.addr[LINE_OFFSET_BITS +: SET_BITS];
    tag     = req.addr[ADDR_BITS-1 -: TAG_BITS];
    s       = shadow_tree[set_idx];
    way     = '0;
    rsp     = '0;
    // lowest matching way wins
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (shadow_valid[set_idx][w] && shadow_tag[set_idx][w] == tag) begin
        rsp.hit = 1'b1;
        way = w[WAY_BITS-1:0];
      end
    end
    if (rsp.hit) begin
      hits_seen++;
    end else begin
      misses_seen++;
      if (&shadow_valid[set_idx]) begin
        // tree victim: top bit picks the half, lower bits the way in it
        way = s[2] ? (s[0] ? 2'd3 : 2'd2) : (s[1] ? 2'd1 : 2'd0);
        if (shadow_dirty[set_idx][way]) begin
          rsp.writeback_needed = 1'b1;
          writebacks_seen++;
        end
      end else begin
        for (int w = NUM_WAYS - 1; w >= 0; w--) begin
          if (!shadow_valid[set_idx][w]) way = w[WAY_BITS-1:0];
        end
      end
      // refilled line starts clean
      shadow_valid[set_idx][way] = 1'b1;
      shadow_dirty[set_idx][way] = 1'b0;
      shadow_tag[set_idx][way]   = tag;
    end
    // point the tree away from the referenced way
    case (way)
      2'd0: shadow_tree[set_idx] = {1'b1, 1'b1, s[0]};
      2'd1: shadow_tree[set_idx] = {1'b1, 1'b0, s[0]};
      2'd2: shadow_tree[set_idx] = {1'b0, s[1], 1'b1};
      default: shadow_tree[set_idx] = {1'b0, s[1], 1'b0};
    endcase
    if (req.req_type == REQ_WRITE) shadow_dirty[set_idx][way] = 1'b1;
    rsp.way_used        = way;
    rsp.hit_total       = hits_seen;
    rsp.miss_total      = misses_seen;
    rsp.writeback_total = writebacks_seen;
    return rsp;
  endfunction

  task automatic queue_access(logic [ADDR_BITS-1:0] a, logic kind);
    access_queue.push_back('{addr: a, req_type: kind});
  endtask

  task automatic check_field(string name, logic [CNT_BITS-1:0] expv,
                             logic [CNT_BITS-1:0] actv);
    if (expv !== actv) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, expv, actv);
      mismatches++;
    end
  endtask

  // Stimulus, reset and end of run
  initial begin
    int made;
    int seq_len;
    int n_tags;
    logic [SET_BITS-1:0] set_sel;
    logic [TAG_BITS-1:0] tag_base;
    logic [TAG_BITS-1:0] tg;
    logic [LINE_OFFSET_BITS-1:0] off;

    for (int i = 0; i < NUM_SETS; i++) begin
      shadow_valid[i] = '0;
      shadow_dirty[i] = '0;
      shadow_tree[i]  = '0;
      for (int w = 0; w < NUM_WAYS; w++) shadow_tag[i][w] = '0;
    end
    hits_seen       = '0;
    misses_seen     = '0;
    writebacks_seen = '0;

    // Directed: address extremes, hits with offsets, fill and evict set 0
    queue_access(32'h0000_0000, REQ_READ);
    queue_access(32'h0000_001F, REQ_WRITE);
    queue_access(32'hFFFF_FFFF, REQ_WRITE);
    queue_access(32'hFFFF_FFE0, REQ_READ);
    queue_access(32'h0000_03E0, REQ_READ);
    queue_access(32'h0000_0400, REQ_WRITE);
    queue_access(32'h0000_0800, REQ_READ);
    queue_access(32'h0000_0C00, REQ_WRITE);
    queue_access(32'h0000_1000, REQ_READ);
    queue_access(32'h0000_1400, REQ_WRITE);
    queue_access(32'h0000_1800, REQ_READ);
    queue_access(32'h0000_1C00, REQ_READ);
    queue_access(32'h0000_0004, REQ_WRITE);
    queue_access(32'h0000_0400, REQ_READ);
    queue_access(32'h0000_0800, REQ_READ);
    queue_access(32'h0000_1000, REQ_WRITE);
    queue_access(32'h0000_2000, REQ_READ);
    queue_access(32'h0000_2400, REQ_WRITE);
    queue_access(32'h0000_0C1F, REQ_READ);
    queue_access(32'h8000_0000, REQ_READ);
    queue_access(32'h7FFF_FC1F, REQ_WRITE);
    queue_access(32'hFFFF_FC00, REQ_READ);

    // Random: mostly small working sets per set, some scattered addresses
    made = 0;
    while (made < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) < 7) begin
        set_sel  = SET_BITS'($urandom_range(0, NUM_SETS - 1));
        tag_base = TAG_BITS'($urandom());
        n_tags   = $urandom_range(3, 7);
        seq_len  = $urandom_range(8, 24);
        for (int i = 0; i < seq_len; i++) begin
          tg  = TAG_BITS'(tag_base + $urandom_range(0, n_tags - 1));
          off = LINE_OFFSET_BITS'($urandom());
          queue_access({tg, set_sel, off}, 1'($urandom_range(0, 1)));
        end
        made += seq_len;
      end else begin
        queue_access($urandom(), 1'($urandom_range(0, 1)));
        made++;
      end
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (access_queue.size() != 0 || in_valid) @(posedge clk);
    while (expected_rsps.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Driver: predicts each accepted transaction, offers the next in bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) expected_rsps.push_back(cache_access(in_data));
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (access_queue.size() != 0) begin
          in_data  <= access_queue.pop_front();
          in_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 20);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: phases of no, light and heavy stall, plus one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      rx_cycles++;
      if (rx_cycles == HOLD_START) hold_left = HOLD_CYCLES;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (phase_left == 0) begin
          stall_mode = $urandom_range(0, 2);
          phase_left = $urandom_range(16, 64);
        end
        phase_left--;
        case (stall_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= 1'($urandom_range(0, 1));
          default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // Monitor: compare each accepted response with the oldest expectation
  always @(posedge clk) begin
    rsp_t exp_rsp;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_rsps.size() == 0) begin
        $display("%0t: unexpected response, expected none, got %0h", $time, out_data);
        mismatches++;
      end else begin
        exp_rsp = expected_rsps.pop_front();
        check_field("hit", CNT_BITS'(exp_rsp.hit), CNT_BITS'(out_data.hit));
        check_field("way_used", CNT_BITS'(exp_rsp.way_used),
                    CNT_BITS'(out_data.way_used));
        check_field("writeback_needed", CNT_BITS'(exp_rsp.writeback_needed),
                    CNT_BITS'(out_data.writeback_needed));
        check_field("hit_total", exp_rsp.hit_total, out_data.hit_total);
        check_field("miss_total", exp_rsp.miss_total, out_data.miss_total);
        check_field("writeback_total", exp_rsp.writeback_total,
                    out_data.writeback_total);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/sacp_pkg.sv
rtl/core/sacp_lookup.sv
rtl/core/set_assoc_cache_tag_plru_top.sv
tb/tb_set_assoc_cache_tag_plru_top.sv
